// ===== rtl/rgbhsv_pkg.sv =====
// Shared widths, hue constants, pipeline payload types and the divider step
// for the RGB to HSV converter. No dependencies.

package rgbhsv_pkg;

  localparam int ChanW       = 5;   // one color channel
  localparam int HueW        = 9;   // hue in degrees, 0..359
  localparam int ByteW       = 8;   // saturation and brightness
  localparam int NumW        = 11;  // 60 * channel difference, up to 1860
  localparam int QuotW       = 6;   // quotient of the hue fraction, up to 60
  localparam int BitsPerStep = 2;   // quotient bits resolved per divider stage
  localparam int DivSteps    = QuotW / BitsPerStep;
  localparam int InDataW     = 16;
  localparam int OutDataW    = 32;
  localparam int ScaleShift  = 3;   // channel to 8-bit scale

  localparam logic [HueW-1:0] HueBaseRed   = HueW'(0);
  localparam logic [HueW-1:0] HueBaseGreen = HueW'(120);
  localparam logic [HueW-1:0] HueBaseBlue  = HueW'(240);
  localparam logic [HueW-1:0] HueFull      = HueW'(360);

  // Fields that ride along with the division and are needed at the end.
  typedef struct packed {
    logic [HueW-1:0]  base;  // sector base, already 360 for negative red hue
    logic             neg;   // channel difference was negative
    logic [ByteW-1:0] sat;
    logic [ByteW-1:0] bri;
  } side_t;

  // Partial remainder and quotient of the restoring division.
  typedef struct packed {
    logic [NumW-1:0]  rem;
    logic [QuotW-1:0] quo;
  } divstate_t;

  // Resolves BitsPerStep quotient bits, starting from the top for step 0.
  function automatic divstate_t div_step(divstate_t cur, logic [ChanW-1:0] den,
                                         int unsigned step);
    divstate_t       nxt;
    logic [NumW-1:0] trial;
    int              sh;
    nxt = cur;
    for (int k = 0; k < BitsPerStep; k++) begin
      sh    = QuotW - 1 - int'(step) * BitsPerStep - k;
      trial = NumW'(den) << sh;
      if (nxt.rem >= trial) begin
        nxt.rem = nxt.rem - trial;
        nxt.quo = nxt.quo | (QuotW'(1) << sh);
      end
    end
    return nxt;
  endfunction

endpackage

// ===== rtl/rgbhsv_div.sv =====
// Pipelined restoring divider for the hue fraction, one stage per two
// quotient bits, with per-stage valid and back-pressure. Uses rgbhsv_pkg.

module rgbhsv_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rgbhsv_pkg::NumW-1:0]    in_num,
  input  logic [rgbhsv_pkg::ChanW-1:0]   in_den,
  input  rgbhsv_pkg::side_t              in_side,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rgbhsv_pkg::QuotW-1:0]   out_quo,
  output logic                           out_rem_nz,
  output rgbhsv_pkg::side_t              out_side
);

  localparam int Last = rgbhsv_pkg::DivSteps - 1;

  logic                            vld  [rgbhsv_pkg::DivSteps];
  logic                            adv  [rgbhsv_pkg::DivSteps];
  rgbhsv_pkg::divstate_t           st   [rgbhsv_pkg::DivSteps];
  logic [rgbhsv_pkg::ChanW-1:0]    den  [rgbhsv_pkg::DivSteps];
  rgbhsv_pkg::side_t               side [rgbhsv_pkg::DivSteps];

  for (genvar k = 0; k < rgbhsv_pkg::DivSteps; k++) begin : g_stage
    logic                          prev_vld;
    rgbhsv_pkg::divstate_t         prev_st;
    logic [rgbhsv_pkg::ChanW-1:0]  prev_den;
    rgbhsv_pkg::side_t             prev_side;

    if (k == 0) begin : g_first
      assign prev_vld  = in_valid;
      assign prev_st   = '{rem: in_num, quo: '0};
      assign prev_den  = in_den;
      assign prev_side = in_side;
    end else begin : g_rest
      assign prev_vld  = vld[k-1];
      assign prev_st   = st[k-1];
      assign prev_den  = den[k-1];
      assign prev_side = side[k-1];
    end

    if (k == Last) begin : g_tail
      assign adv[k] = !vld[k] || out_ready;
    end else begin : g_mid
      assign adv[k] = !vld[k] || adv[k+1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv[k]) begin
        vld[k] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        st[k]   <= rgbhsv_pkg::div_step(prev_st, prev_den, k);
        den[k]  <= prev_den;
        side[k] <= prev_side;
      end
    end
  end

  assign in_ready   = adv[0];
  assign out_valid  = vld[Last];
  assign out_quo    = st[Last].quo;
  assign out_rem_nz = (st[Last].rem != '0);
  assign out_side   = side[Last];

endmodule

// ===== rtl/rgb_to_hsv_converter.sv =====
// Top level of the RGB to HSV converter: channel compare, scaling, the
// pipelined hue divider and the output register. Uses rgbhsv_pkg, rgbhsv_div.

// The converter takes one 5-bit-per-channel pixel per beat and returns hue in
// whole degrees (0..359), saturation ((max - min) * 8) and brightness
// (max * 8). Hue is 0 for grey and black pixels; otherwise the largest
// channel picks the sector, red winning ties over green and green over blue,
// and the fractional part 60 * difference / spread is rounded down, with 360
// added when the red-sector hue would be negative. The block is a six-stage
// pipeline: channel compare, the multiply by 60, three divider stages that
// each resolve two quotient bits, and the output register. The edge that
// accepts a beat loads the first stage, and the beat passes through the
// stages in that order; a new pixel can be accepted every cycle while the
// pipeline is not stalled. Every stage has its own valid bit and advances
// whenever its successor has room, so stalls on the output side lose no
// beat and bubbles inside the pipeline are squeezed out.

module rgb_to_hsv_converter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // red [4:0], green [9:5], blue [14:10], zero [15]
  input  logic [rgbhsv_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // hue [8:0], saturation [16:9], brightness [24:17], zero [31:25]
  output logic [rgbhsv_pkg::OutDataW-1:0]     m_axis_tdata
);

  localparam int CW = rgbhsv_pkg::ChanW;
  localparam int HW = rgbhsv_pkg::HueW;
  localparam int BW = rgbhsv_pkg::ByteW;
  localparam int NW = rgbhsv_pkg::NumW;

  // ---------------------------------------------------------------------
  // Stage 1: find max and min, the sector and the signed channel
  // difference of that sector.
  // ---------------------------------------------------------------------
  logic [CW-1:0]     red, green, blue;
  logic [CW-1:0]     mx, mn, spread, first, second, adiff;
  logic              neg;
  logic [HW-1:0]     base;
  logic              red_max, green_max;
  rgbhsv_pkg::side_t s1_side_next;

  assign red   = s_axis_tdata[CW-1:0];
  assign green = s_axis_tdata[2*CW-1:CW];
  assign blue  = s_axis_tdata[3*CW-1:2*CW];

  always_comb begin
    red_max   = (red >= green) && (red >= blue);
    green_max = !red_max && (green >= blue);
    if (red_max) begin
      mx     = red;
      first  = green;
      second = blue;
    end else if (green_max) begin
      mx     = green;
      first  = blue;
      second = red;
    end else begin
      mx     = blue;
      first  = red;
      second = green;
    end
    mn = red;
    if (green < mn) begin
      mn = green;
    end
    if (blue < mn) begin
      mn = blue;
    end
    spread = mx - mn;
    neg    = (first < second);
    adiff  = neg ? (second - first) : (first - second);
    // A negative red-sector hue wraps around from 360.
    if (red_max) begin
      base = neg ? rgbhsv_pkg::HueFull : rgbhsv_pkg::HueBaseRed;
    end else if (green_max) begin
      base = rgbhsv_pkg::HueBaseGreen;
    end else begin
      base = rgbhsv_pkg::HueBaseBlue;
    end
    s1_side_next.base = base;
    s1_side_next.neg  = neg;
    s1_side_next.sat  = BW'(spread) << rgbhsv_pkg::ScaleShift;
    s1_side_next.bri  = BW'(mx) << rgbhsv_pkg::ScaleShift;
  end

  logic              s1_vld, s1_adv;
  logic [CW-1:0]     s1_adiff, s1_den;
  rgbhsv_pkg::side_t s1_side;

  // ---------------------------------------------------------------------
  // Stage 2: numerator 60 * |difference| as two shifts and a subtract.
  // ---------------------------------------------------------------------
  logic              s2_vld, s2_adv;
  logic [NW-1:0]     s2_num;
  logic [CW-1:0]     s2_den;
  rgbhsv_pkg::side_t s2_side;
  logic [NW-1:0]     num_next;

  assign num_next = (NW'(s1_adiff) << 6) - (NW'(s1_adiff) << 2);

  // Divider and output stage.
  logic                         div_in_ready, div_out_valid, div_rem_nz;
  logic [rgbhsv_pkg::QuotW-1:0] div_quo;
  rgbhsv_pkg::side_t            div_side;
  logic                         out_adv;
  logic [HW-1:0]                hue_next;

  assign out_adv = !m_axis_tvalid || m_axis_tready;
  assign s2_adv  = !s2_vld || div_in_ready;
  assign s1_adv  = !s1_vld || s2_adv;
  assign s_axis_tready = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_vld <= s_axis_tvalid;
      end
      if (s2_adv) begin
        s2_vld <= s1_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      // A grey pixel has zero difference; a divisor of one keeps the hue at 0.
      s1_adiff <= adiff;
      s1_den   <= (spread == '0) ? CW'(1) : spread;
      s1_side  <= s1_side_next;
    end
    if (s2_adv) begin
      s2_num  <= num_next;
      s2_den  <= s1_den;
      s2_side <= s1_side;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 3 to 5: quotient and remainder of the hue fraction.
  // ---------------------------------------------------------------------
  rgbhsv_div u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s2_vld),
    .in_ready   (div_in_ready),
    .in_num     (s2_num),
    .in_den     (s2_den),
    .in_side    (s2_side),
    .out_valid  (div_out_valid),
    .out_ready  (out_adv),
    .out_quo    (div_quo),
    .out_rem_nz (div_rem_nz),
    .out_side   (div_side)
  );

  // ---------------------------------------------------------------------
  // Stage 6: apply the sign with floor rounding and register the beat.
  // For a negative difference, floor(-q - frac) is -q - 1 unless exact.
  // ---------------------------------------------------------------------
  assign hue_next = div_side.neg
                    ? (div_side.base - HW'(div_quo) - HW'(div_rem_nz))
                    : (div_side.base + HW'(div_quo));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_axis_tvalid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      m_axis_tdata <= {(rgbhsv_pkg::OutDataW - HW - 2 * BW)'(0),
                       div_side.bri, div_side.sat, hue_next};
    end
  end

endmodule

// ===== rtl/rgbhsv_checker.sv =====
// Port-level checks for the RGB to HSV converter, bound to the top level.
// Uses rgbhsv_pkg for the field widths.

module rgbhsv_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rgbhsv_pkg::OutDataW-1:0]  m_axis_tdata
);

  logic [rgbhsv_pkg::HueW-1:0]  hue;
  logic [rgbhsv_pkg::ByteW-1:0] sat, bri;

  assign hue = m_axis_tdata[rgbhsv_pkg::HueW-1:0];
  assign sat = m_axis_tdata[rgbhsv_pkg::HueW+rgbhsv_pkg::ByteW-1:rgbhsv_pkg::HueW];
  assign bri = m_axis_tdata[rgbhsv_pkg::HueW+2*rgbhsv_pkg::ByteW-1:
                            rgbhsv_pkg::HueW+rgbhsv_pkg::ByteW];

  // A stalled result beat holds its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Hue stays below a full turn.
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> hue < rgbhsv_pkg::HueFull)
    else $error("hue out of range");

  // Grey and black pixels have hue zero.
  a_grey: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && sat == '0 |-> hue == '0)
    else $error("grey pixel with nonzero hue");

  // The spread never exceeds the maximum, and both are multiples of eight.
  a_scale: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> sat <= bri && sat[2:0] == 3'b000 && bri[2:0] == 3'b000)
    else $error("saturation or brightness inconsistent");

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_rgbhsv_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
